@@ rtl/fixed_block_allocator_core_macros.svh @@
// assertion helpers used by the allocator core rtl
`ifndef FIXED_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// clocked check, muted while reset is asserted
`define FBA_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check, also active during reset
`define FBA_CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/fba_pkg.sv @@
package fba_pkg;

	// command codes carried in the input tuser
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// reset value of the block size register
	localparam logic [4:0] WPB_RESET = 5'd8;

	// start word of the first block
	localparam int FIRST_START = 2;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_PROBE,
		S_EVAL,
		S_FREE,
		S_DONE
	} fba_state_t;

	// compare results of the shared address unit
	typedef struct packed {
		logic sum_gt_store;
		logic op_ge_top;
		logic op_eq_top;
		logic sum_eq_top;
	} fba_flags_t;

endpackage

@@ rtl/fixed_block_allocator_core.sv @@
// fixed-size block allocator, one command at a time through a small sequencer
// allocate: check, which may refuse, then probe, which takes the top block; a hole below top
//   is read in probe and reused in eval, each occupied block before it adding a probe and eval
// free: the free state; then done holds the result; the input is ready only in idle, and a result
//   held by m_tready low keeps the sequencer waiting and the input not ready
// arst_n clears the sequencer, output valid, top index (2) and block size (8); marks not cleared
module fixed_block_allocator_core #(
	parameter int STORE_WORDS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: words_per_block
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	// command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] request_words, [12:8] free_address, rest zero
	input  logic [0:0]  s_tuser,  // [0] cmd
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [4:0] block_address, rest zero
	output logic [0:0]  m_tuser   // [0] granted
);

	`include "fixed_block_allocator_core_macros.svh"

	localparam int TW = $clog2(STORE_WORDS + 32);
	localparam int AW = $clog2(STORE_WORDS);

	fba_pkg::fba_state_t state_q, state_n;

	logic [TW-1:0] top_q;
	logic [4:0]    wpb_q;
	logic [TW-1:0] cur_q;
	logic [7:0]    req_q;
	logic [4:0]    addr_q;
	logic          res_granted_q;
	logic [4:0]    res_addr_q;
	logic          out_valid_q;
	logic          out_granted_q;
	logic [4:0]    out_addr_q;

	logic [TW-1:0]        operand;
	logic [TW-1:0]        sum;
	fba_pkg::fba_flags_t  flags;
	logic [TW-1:0]        cur_idx;
	logic [TW-1:0]        free_idx;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic          mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic          mem_rdata;

	logic          top_load;
	logic [TW-1:0] top_n;
	logic          cur_step;
	logic          res_load;
	logic          res_g;
	logic [4:0]    res_a;
	logic          out_load;
	logic          in_fire;

	// handshakes
	assign cfg_ready = 1'b1;
	assign s_tready  = state_q == fba_pkg::S_IDLE;
	assign in_fire   = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {3'b000, out_addr_q};
	assign m_tuser   = out_granted_q;

	// header word index of the scan candidate and of the block being freed
	assign cur_idx  = cur_q - TW'(1);
	assign free_idx = TW'(addr_q) - TW'(1);

	// operand select for the shared unit
	always_comb begin
		unique case (state_q)
			fba_pkg::S_CHECK: operand = top_q;
			fba_pkg::S_FREE:  operand = TW'(addr_q);
			default:          operand = cur_q;
		endcase
	end

	fba_addr_unit #(
		.TW          (TW),
		.STORE_WORDS (STORE_WORDS)
	) u_addr (
		.operand (operand),
		.wpb     (wpb_q),
		.top     (top_q),
		.sum     (sum),
		.flags   (flags)
	);

	fba_mark_ram #(
		.DEPTH (STORE_WORDS)
	) u_marks (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// sequencer next state and controls
	always_comb begin
		state_n   = state_q;
		mem_we    = 1'b0;
		mem_waddr = cur_idx[AW-1:0];
		mem_wdata = 1'b1;
		mem_re    = 1'b0;
		mem_raddr = cur_idx[AW-1:0];
		top_load  = 1'b0;
		top_n     = sum;
		cur_step  = 1'b0;
		res_load  = 1'b0;
		res_g     = 1'b1;
		res_a     = cur_q[4:0];
		out_load  = 1'b0;
		unique case (state_q)
			fba_pkg::S_IDLE: begin
				if (in_fire) begin
					state_n = (s_tuser[0] == fba_pkg::CMD_FREE) ? fba_pkg::S_FREE
					                                             : fba_pkg::S_CHECK;
				end
			end
			fba_pkg::S_CHECK: begin
				if (wpb_q == 5'd0 || flags.sum_gt_store || req_q > {3'b000, wpb_q}) begin
					res_load = 1'b1;
					res_g    = 1'b0;
					res_a    = 5'd0;
					state_n  = fba_pkg::S_DONE;
				end else begin
					state_n = fba_pkg::S_PROBE;
				end
			end
			fba_pkg::S_PROBE: begin
				if (flags.op_ge_top) begin
					// nothing free below top, take the block at the candidate
					mem_we   = 1'b1;
					top_load = flags.op_eq_top;
					res_load = 1'b1;
					state_n  = fba_pkg::S_DONE;
				end else begin
					mem_re  = 1'b1;
					state_n = fba_pkg::S_EVAL;
				end
			end
			fba_pkg::S_EVAL: begin
				if (!mem_rdata) begin
					mem_we   = 1'b1;
					res_load = 1'b1;
					state_n  = fba_pkg::S_DONE;
				end else begin
					cur_step = 1'b1;
					state_n  = fba_pkg::S_PROBE;
				end
			end
			fba_pkg::S_FREE: begin
				mem_we    = addr_q != 5'd0 && free_idx < TW'(STORE_WORDS);
				mem_waddr = free_idx[AW-1:0];
				mem_wdata = 1'b0;
				top_load  = flags.sum_eq_top && addr_q >= 5'd2;
				top_n     = TW'(addr_q);
				res_load  = 1'b1;
				res_a     = addr_q;
				state_n   = fba_pkg::S_DONE;
			end
			fba_pkg::S_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_n  = fba_pkg::S_IDLE;
				end
			end
			default: begin
				state_n = fba_pkg::S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fba_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// top index and block size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= TW'(fba_pkg::FIRST_START);
			wpb_q <= fba_pkg::WPB_RESET;
		end else begin
			if (top_load) begin
				top_q <= top_n;
			end
			if (cfg_valid && cfg_ready) begin
				wpb_q <= cfg_data;
			end
		end
	end

	// command capture and scan pointer
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q  <= s_tdata[7:0];
			addr_q <= s_tdata[12:8];
			cur_q  <= TW'(fba_pkg::FIRST_START);
		end else if (cur_step) begin
			cur_q <= sum;
		end
		if (res_load) begin
			res_granted_q <= res_g;
			res_addr_q    <= res_a;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_granted_q <= res_granted_q;
			out_addr_q    <= res_addr_q;
		end
	end

	// checks
	`FBA_CHECK(a_top_floor, top_q >= TW'(fba_pkg::FIRST_START), "top index below first block")
	`FBA_CHECK(a_refused_zero, m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0, "refusal with address")
	`FBA_CHECK(a_top_moves, !$stable(top_q) |-> $past(top_load), "top index moved without a load")

endmodule

@@ rtl/fba_mark_ram.sv @@
module fba_mark_ram #(
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic                     wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic                     rdata
);

	logic mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/fba_addr_unit.sv @@
module fba_addr_unit #(
	parameter int TW          = 6,
	parameter int STORE_WORDS = 32
) (
	input  logic [TW-1:0]          operand,
	input  logic [4:0]             wpb,
	input  logic [TW-1:0]          top,
	output logic [TW-1:0]          sum,
	output fba_pkg::fba_flags_t    flags
);

	// one adder shared by the limit check, the scan step and the top drop
	assign sum = operand + TW'(wpb);

	// compares against the store size and the top index
	always_comb begin
		flags.sum_gt_store = sum > TW'(STORE_WORDS);
		flags.op_ge_top    = operand >= top;
		flags.op_eq_top    = operand == top;
		flags.sum_eq_top   = sum == top;
	end

endmodule

@@ bench/tb.sv @@
module tb;

	localparam int STORE_WORDS = 32;
	// the limit lies far beyond the longest allocate, one with every block probed, and any real gap
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		logic       granted;
		logic [4:0] block_address;
	} grant_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;  // [7:0] request_words, [12:8] free_address, rest zero
	logic [0:0]  s_tuser;  // [0] cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;  // [4:0] block_address, rest zero
	logic [0:0]  m_tuser;  // [0] granted

	fixed_block_allocator_core #(
		.STORE_WORDS(STORE_WORDS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// allocator state as the block should hold it
	logic [4:0]             blk_words;
	int                     top_word;
	logic [STORE_WORDS-1:0] used_mark;

	grant_t pending_grants[$];
	int     mismatches = 0;
	int     items_sent;
	int     results_seen = 0;
	int     refusals;
	int     stall_cycles = 0;
	bit     steady_run;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// expected grant for one command, updates top and marks
	function automatic grant_t predict_grant(input logic cmd, input logic [7:0] req,
			input logic [4:0] addr);
		grant_t r;
		int     start;
		r = '0;
		if (cmd == fba_pkg::CMD_ALLOC) begin
			if (blk_words == 0 || top_word + blk_words > STORE_WORDS || req > blk_words) begin
				refusals++;
			end else begin
				// first fit: stop at the first clear mark or at the top
				start = fba_pkg::FIRST_START;
				while (start < top_word && used_mark[start-1])
					start += blk_words;
				used_mark[start-1] = 1'b1;
				if (start == top_word)
					top_word += blk_words;
				r.granted = 1'b1;
				r.block_address = start[4:0];
			end
		end else begin
			// a free is never checked; word 0 has no header
			if (addr != 0)
				used_mark[addr-1] = 1'b0;
			if (top_word >= blk_words + 2 && top_word - blk_words == addr)
				top_word -= blk_words;
			r.granted = 1'b1;
			r.block_address = addr;
		end
		return r;
	endfunction

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// result checker
	always @(posedge clk) begin : check_result
		grant_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_grants.size() == 0) begin
				report($sformatf("result with nothing pending: granted %0b address %0d",
					m_tuser[0], m_tdata[4:0]));
			end else begin
				want = pending_grants.pop_front();
				if (m_tuser[0] !== want.granted)
					report($sformatf("granted: expected %0b, got %0b", want.granted, m_tuser[0]));
				if (m_tdata[4:0] !== want.block_address)
					report($sformatf("block_address: expected %0d, got %0d",
						want.block_address, m_tdata[4:0]));
			end
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, pending_grants.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		m_tready <= steady_run || ($urandom_range(99) >= 37);
	end

	// one command transaction, entered and left at a falling edge
	task automatic send_cmd(input logic cmd, input logic [7:0] req, input logic [4:0] addr);
		while (!steady_run && $urandom_range(99) < 37) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {3'b000, addr, req};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_grants.push_back(predict_grant(cmd, req, addr));
		items_sent++;
		@(negedge clk);
	endtask

	// hold the command side until every pending result is back
	task automatic wait_results();
		s_tvalid <= 1'b0;
		while (pending_grants.size() != 0)
			@(negedge clk);
	endtask

	// free the last block until top is back at the first start
	task automatic return_to_base();
		while (top_word > fba_pkg::FIRST_START)
			send_cmd(fba_pkg::CMD_FREE, 8'($urandom_range(255)), 5'(top_word - blk_words));
		wait_results();
	endtask

	// block size only changes with no block below top, so no stale mark is ever scanned
	task automatic write_block_size(input logic [4:0] size);
		return_to_base();
		cfg_valid <= 1'b1;
		cfg_data  <= size;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		blk_words = size;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// well-formed mix: allocates, frees of real blocks, of the last block, and stray frees
	task automatic issue_random_cmd(input int alloc_pct);
		int         pick;
		int         nblk;
		int         start;
		logic [7:0] req;
		logic [4:0] addr;
		pick = $urandom_range(99);
		req  = 8'($urandom_range(255));
		addr = 5'($urandom_range(31));
		nblk = (top_word - fba_pkg::FIRST_START) / blk_words;
		if (pick < alloc_pct) begin
			if ($urandom_range(9) != 0)
				req = 8'($urandom_range(blk_words));
			send_cmd(fba_pkg::CMD_ALLOC, req, addr);
		end else if (pick < alloc_pct + (100 - alloc_pct) * 3 / 5 && nblk > 0) begin
			start = fba_pkg::FIRST_START + $urandom_range(nblk - 1) * blk_words;
			send_cmd(fba_pkg::CMD_FREE, req, 5'(start));
		end else if (pick < 92 && nblk > 0) begin
			send_cmd(fba_pkg::CMD_FREE, req, 5'(top_word - blk_words));
		end else begin
			send_cmd(fba_pkg::CMD_FREE, req, addr);
		end
	endtask

	task automatic run_random_phase(input logic [4:0] size, input int count, input int alloc_pct);
		write_block_size(size);
		repeat (count)
			issue_random_cmd(alloc_pct);
	endtask

	// directed at the reset block size of 8
	task automatic test_reset_size();
		send_cmd(fba_pkg::CMD_ALLOC, 8'd0, 5'd0);
		send_cmd(fba_pkg::CMD_ALLOC, 8'd8, 5'd31);
		send_cmd(fba_pkg::CMD_ALLOC, 8'd9, 5'd0);     // larger than a block
		send_cmd(fba_pkg::CMD_ALLOC, 8'd255, 5'd0);
		send_cmd(fba_pkg::CMD_ALLOC, 8'd1, 5'd0);
		send_cmd(fba_pkg::CMD_ALLOC, 8'd3, 5'd0);     // top full
		send_cmd(fba_pkg::CMD_FREE, 8'd0, 5'd10);     // hole below top
		send_cmd(fba_pkg::CMD_FREE, 8'd255, 5'd0);    // word 0 has no header
		send_cmd(fba_pkg::CMD_ALLOC, 8'd8, 5'd0);     // refused on top even with a hole
		send_cmd(fba_pkg::CMD_FREE, 8'd0, 5'd18);     // last block, top drops
		send_cmd(fba_pkg::CMD_ALLOC, 8'd4, 5'd0);     // refills the hole
		send_cmd(fba_pkg::CMD_FREE, 8'd0, 5'd31);     // stray address
		return_to_base();
		send_cmd(fba_pkg::CMD_FREE, 8'd0, 5'd2);      // top stays at its floor
		wait_results();
	endtask

	// directed at block sizes 1 and 30
	task automatic test_size_extremes();
		write_block_size(5'd1);
		send_cmd(fba_pkg::CMD_FREE, 8'd0, 5'd1);  // top minus size matches but is below the floor
		send_cmd(fba_pkg::CMD_ALLOC, 8'd1, 5'd0);
		send_cmd(fba_pkg::CMD_ALLOC, 8'd2, 5'd0);
		send_cmd(fba_pkg::CMD_ALLOC, 8'd0, 5'd0);
		send_cmd(fba_pkg::CMD_FREE, 8'd0, 5'd2);
		send_cmd(fba_pkg::CMD_ALLOC, 8'd1, 5'd0);
		write_block_size(5'd30);
		send_cmd(fba_pkg::CMD_ALLOC, 8'd30, 5'd0);
		send_cmd(fba_pkg::CMD_ALLOC, 8'd0, 5'd0);
		send_cmd(fba_pkg::CMD_FREE, 8'd0, 5'd2);
		wait_results();
	endtask

	// random traffic over a range of block sizes
	task automatic test_random_sizes();
		int sizes[10] = '{1, 30, 5, 16, 2, 21, 10, 13, 1, 7};
		int bias[10]  = '{70, 50, 60, 45, 65, 55, 40, 60, 55, 50};
		for (int p = 0; p < 10; p++)
			run_random_phase(5'(sizes[p]), 95, bias[p]);
		wait_results();
	endtask

	// no idling on either side
	task automatic test_back_to_back();
		steady_run = 1'b1;
		run_random_phase(5'd4, 150, 55);
		wait_results();
		steady_run = 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = fba_pkg::WPB_RESET;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = fba_pkg::CMD_ALLOC;
		steady_run   = 1'b0;
		items_sent   = 0;
		refusals     = 0;
		blk_words    = fba_pkg::WPB_RESET;
		top_word     = fba_pkg::FIRST_START;
		used_mark    = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_size();
		test_size_extremes();
		test_random_sizes();
		test_back_to_back();

		// let any stray result show up
		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_grants.size() != 0)
			report($sformatf("%0d results never arrived", pending_grants.size()));

		$display("%0d commands sent, %0d results checked, %0d allocations refused",
			items_sent, results_seen, refusals);
		$display("covered block sizes 1 to 30, holes, full store, stray frees, back-to-back");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/fba_pkg.sv
rtl/fba_mark_ram.sv
rtl/fba_addr_unit.sv
rtl/fixed_block_allocator_core.sv
bench/tb.sv
